[sv/gravity_pair_force_2d_assert.svh]
// Assertion macros shared by the checker of the pair force block.
`ifndef GRAVITY_PAIR_FORCE_2D_ASSERT_SVH
`define GRAVITY_PAIR_FORCE_2D_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define GPF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpf: same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define GPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpf: next-cycle check failed");

`endif

[sv/gpf_pkg.sv]
`timescale 1ns / 1ps
package gpf_pkg;

  // Fixed field widths
  localparam int GRAV_W     = 32;
  localparam int MASS_W     = 32;
  localparam int DSQ_W      = 48;
  localparam int OUT_W      = 48;
  localparam int PROD_W     = GRAV_W + 2 * MASS_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // Width of one partial product slice in the multipliers
  localparam int MUL_CH = 32;

  // Register reset values
  localparam logic [GRAV_W-1:0] GRAV_RESET    = GRAV_W'(65536);
  localparam logic [DSQ_W-1:0]  MIN_DSQ_RESET = DSQ_W'(327680);
  localparam logic [DSQ_W-1:0]  MAX_DSQ_RESET = DSQ_W'(6553600);

  // Output limits, as magnitudes
  localparam logic [OUT_W-1:0] OUT_POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_NEG_MAG = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAV    = 2'd0,
    CFG_MIN_DSQ = 2'd1,
    CFG_MAX_DSQ = 2'd2
  } cfg_idx_t;

  // Per-pair flags carried alongside the datapath
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
  } side_t;

  // One saturated force component
  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             clip;
  } comp_t;

  // Cycles from the accepting edge to the edge that takes the result
  function automatic int gpf_result_lat(input int pos_w);
    int aw;
    int sw;
    int rw;
    int lsq;
    int tm;
    int magw;
    int ln;
    int to;
    aw   = pos_w + 1;
    sw   = 2 * aw + 1;
    rw   = (sw + 1) / 2;
    lsq  = (aw + MUL_CH - 1) / MUL_CH;
    tm   = lsq + 3 + PROD_W + 1;
    magw = OUT_W + rw + 1;
    ln   = (magw + MUL_CH - 1) / MUL_CH;
    to   = tm + ln + 1;
    return to + OUT_W + 2;
  endfunction

endpackage

[sv/gravity_pair_force_2d.sv]
`timescale 1ns / 1ps
// Channel     | Direction | Handshake              | Payload
// ------------+-----------+------------------------+-------------------------------------
// pair in     | in        | start / busy           | a_pos_x/y, b_pos_x/y, a_mass, b_mass
// force out   | out       | done (one-cycle strobe)| force_x, force_y, saturated
// config      | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pair is taken every cycle; busy is high only during reset.
// done pulses once per accepted pair; the latency is set by the 96-step magnitude
// divider and the 48-step component dividers.
// Reset clears the valid chain, the configuration registers and saturated; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
module gravity_pair_force_2d #(
  parameter int POS_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [POS_WIDTH-1:0]    a_pos_x,
  input  logic signed [POS_WIDTH-1:0]    a_pos_y,
  input  logic signed [POS_WIDTH-1:0]    b_pos_x,
  input  logic signed [POS_WIDTH-1:0]    b_pos_y,
  input  logic [gpf_pkg::MASS_W-1:0]     a_mass,
  input  logic [gpf_pkg::MASS_W-1:0]     b_mass,
  output logic                           done,
  output logic signed [gpf_pkg::OUT_W-1:0] force_x,
  output logic signed [gpf_pkg::OUT_W-1:0] force_y,
  output logic                           saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gpf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import gpf_pkg::*;

  localparam int AW    = POS_WIDTH + 1;
  localparam int SW    = 2 * AW + 1;
  localparam int RW    = (SW + 1) / 2;
  localparam int LSQ   = (AW + MUL_CH - 1) / MUL_CH;
  localparam int LR    = RW;
  localparam int LG    = (GRAV_W + MUL_CH - 1) / MUL_CH;
  localparam int LGM   = (GRAV_W + MASS_W + MUL_CH - 1) / MUL_CH;
  localparam int TP    = LG + LGM;
  localparam int TS    = LSQ + 2;
  localparam int TC    = TS + 1;
  localparam int TM    = TC + PROD_W + 1;
  localparam int MAG_W = OUT_W + RW + 1;
  localparam int NUMW  = MAG_W + AW;
  localparam int HW    = NUMW - OUT_W;
  localparam int LN    = (MAG_W + MUL_CH - 1) / MUL_CH;
  localparam int TO    = TM + LN + 1;
  localparam int TF    = TO + OUT_W + 1;
  localparam int DEN_W = DSQ_W + FRAC_BITS;
  localparam int CW    = (SW - FRAC_BITS > DSQ_W) ? SW - FRAC_BITS : DSQ_W;
  localparam int XW    = (MAG_W > PROD_W) ? MAG_W : PROD_W;

  logic              accept;
  logic [TF:0]       vp;
  logic [GRAV_W-1:0] grav;
  logic [DSQ_W-1:0]  min_dsq;
  logic [DSQ_W-1:0]  max_dsq;

  // Configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav    <= GRAV_RESET;
      min_dsq <= MIN_DSQ_RESET;
      max_dsq <= MAX_DSQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRAV:    grav    <= cfg_data[GRAV_W-1:0];
        CFG_MIN_DSQ: min_dsq <= cfg_data[DSQ_W-1:0];
        CFG_MAX_DSQ: max_dsq <= cfg_data[DSQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Transfer in and the valid chain
  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else begin
      vp <= {vp[TF-1:0], accept};
    end
  end

  // Stage 0: differences and masses
  logic [AW-1:0]     dx0;
  logic [AW-1:0]     dy0;
  logic [MASS_W-1:0] ma0;
  logic [MASS_W-1:0] mb0;

  always_ff @(posedge clk) begin
    if (accept) begin
      dx0 <= {b_pos_x[POS_WIDTH-1], b_pos_x} - {a_pos_x[POS_WIDTH-1], a_pos_x};
      dy0 <= {b_pos_y[POS_WIDTH-1], b_pos_y} - {a_pos_y[POS_WIDTH-1], a_pos_y};
      ma0 <= a_mass;
      mb0 <= b_mass;
    end
  end

  // Stage 1: magnitudes and signs
  logic [AW-1:0] ax1;
  logic [AW-1:0] ay1;
  side_t         side1;

  always_ff @(posedge clk) begin
    ax1         <= dx0[AW-1] ? -dx0 : dx0;
    ay1         <= dy0[AW-1] ? -dy0 : dy0;
    side1.neg_x <= dx0[AW-1];
    side1.neg_y <= dy0[AW-1];
    side1.zero  <= (dx0 == '0) && (dy0 == '0);
  end

  // Squared distance
  logic [2*AW-1:0] sqx;
  logic [2*AW-1:0] sqy;
  logic [SW-1:0]   s_ts;

  gpf_mul #(.WA(AW), .WB(AW)) u_sqx (.clk(clk), .a(ax1), .b(ax1), .p(sqx));
  gpf_mul #(.WA(AW), .WB(AW)) u_sqy (.clk(clk), .a(ay1), .b(ay1), .p(sqy));

  always_ff @(posedge clk) begin
    s_ts <= {1'b0, sqx} + {1'b0, sqy};
  end

  // Distance for the unit vector
  logic [RW-1:0] root_s;
  logic [RW-1:0] root_n;

  gpf_sqrt #(.IW(SW)) u_sqrt (.clk(clk), .x(s_ts), .root(root_s));

  gpf_delay #(.W(RW), .D(TM + LN - TS - LR)) u_root_dly (
    .clk(clk), .d(root_s), .q(root_n)
  );

  // Clamp the squared distance: lower limit first, then upper
  logic [CW-1:0]    dsq_full;
  logic [CW-1:0]    lo_lim;
  logic [CW-1:0]    hi_lim;
  logic [CW-1:0]    dsq_lo;
  logic [CW-1:0]    dsq_cl;
  logic [DSQ_W-1:0] dc;
  logic [DEN_W-1:0] den;

  assign dsq_full = CW'(s_ts >> FRAC_BITS);
  assign lo_lim   = CW'(min_dsq);
  assign hi_lim   = CW'(max_dsq);
  assign dsq_lo   = (dsq_full < lo_lim) ? lo_lim : dsq_full;
  assign dsq_cl   = (dsq_lo > hi_lim) ? hi_lim : dsq_lo;

  always_ff @(posedge clk) begin
    dc <= dsq_cl[DSQ_W-1:0];
  end

  assign den = {dc, {FRAC_BITS{1'b0}}};

  // G * mA * mB
  logic [GRAV_W+MASS_W-1:0] gm;
  logic [MASS_W-1:0]        mb_d;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-1:0]        prod_c;

  gpf_mul #(.WA(GRAV_W), .WB(MASS_W)) u_gm (.clk(clk), .a(grav), .b(ma0), .p(gm));

  gpf_delay #(.W(MASS_W), .D(LG)) u_mb_dly (.clk(clk), .d(mb0), .q(mb_d));

  gpf_mul #(.WA(GRAV_W + MASS_W), .WB(MASS_W)) u_gmm (
    .clk(clk), .a(gm), .b(mb_d), .p(prod)
  );

  gpf_delay #(.W(PROD_W), .D(TC - TP)) u_prod_dly (.clk(clk), .d(prod), .q(prod_c));

  // Force magnitude; a zero divisor yields all ones and so saturates
  logic [PROD_W-1:0] mag_q;
  logic [XW-1:0]     mag_x;
  logic [XW-1:0]     cap_x;
  logic [MAG_W-1:0]  magc;

  gpf_div #(.NW(PROD_W), .DW(DEN_W)) u_mag_div (
    .clk(clk), .rem_in('0), .num_in(prod_c), .den(den), .quo(mag_q)
  );

  // Cap the magnitude where every nonzero component clips anyway
  assign mag_x = XW'(mag_q);
  assign cap_x = XW'(1) << (OUT_W + RW);

  always_ff @(posedge clk) begin
    magc <= (mag_x >= cap_x) ? cap_x[MAG_W-1:0] : mag_x[MAG_W-1:0];
  end

  // Scale by |d| per axis
  logic [AW-1:0]   axm;
  logic [AW-1:0]   aym;
  logic [NUMW-1:0] numx;
  logic [NUMW-1:0] numy;

  gpf_delay #(.W(2 * AW), .D(TM - 1)) u_abs_dly (
    .clk(clk), .d({ax1, ay1}), .q({axm, aym})
  );

  gpf_mul #(.WA(MAG_W), .WB(AW)) u_numx (.clk(clk), .a(magc), .b(axm), .p(numx));
  gpf_mul #(.WA(MAG_W), .WB(AW)) u_numy (.clk(clk), .a(magc), .b(aym), .p(numy));

  // Flag quotients of 2^OUT_W or more before the short division
  logic [HW-1:0]    hix;
  logic [HW-1:0]    hiy;
  logic             ovfx;
  logic             ovfy;
  logic [RW-1:0]    remx0;
  logic [RW-1:0]    remy0;
  logic [OUT_W-1:0] lowx;
  logic [OUT_W-1:0] lowy;
  logic [RW-1:0]    root_o;

  assign hix = numx[NUMW-1:OUT_W];
  assign hiy = numy[NUMW-1:OUT_W];

  always_ff @(posedge clk) begin
    ovfx   <= hix >= HW'(root_n);
    ovfy   <= hiy >= HW'(root_n);
    remx0  <= hix[RW-1:0];
    remy0  <= hiy[RW-1:0];
    lowx   <= numx[OUT_W-1:0];
    lowy   <= numy[OUT_W-1:0];
    root_o <= root_n;
  end

  logic [OUT_W-1:0] qx;
  logic [OUT_W-1:0] qy;

  gpf_div #(.NW(OUT_W), .DW(RW)) u_divx (
    .clk(clk), .rem_in(remx0), .num_in(lowx), .den(root_o), .quo(qx)
  );
  gpf_div #(.NW(OUT_W), .DW(RW)) u_divy (
    .clk(clk), .rem_in(remy0), .num_in(lowy), .den(root_o), .quo(qy)
  );

  // Align flags with the quotients
  logic  ovfx_f;
  logic  ovfy_f;
  side_t side_f;

  gpf_delay #(.W(2), .D(OUT_W)) u_ovf_dly (
    .clk(clk), .d({ovfx, ovfy}), .q({ovfx_f, ovfy_f})
  );

  gpf_delay #(.W($bits(side_t)), .D(TO + OUT_W - 1)) u_side_dly (
    .clk(clk), .d(side1), .q(side_f)
  );

  // Clip one component to range and apply its sign
  function automatic comp_t sat_comp(input logic [OUT_W-1:0] q, input logic ovf,
                                     input logic neg);
    comp_t            r;
    logic             clip;
    logic [OUT_W-1:0] m;
    if (neg) begin
      clip = ovf || (q > OUT_NEG_MAG);
    end else begin
      clip = ovf || q[OUT_W-1];
    end
    if (clip) begin
      m = neg ? OUT_NEG_MAG : OUT_POS_MAX;
    end else begin
      m = q;
    end
    r.value = neg ? -m : m;
    r.clip  = clip;
    return r;
  endfunction

  comp_t rx;
  comp_t ry;

  assign rx = sat_comp(qx, ovfx_f, side_f.neg_x);
  assign ry = sat_comp(qy, ovfy_f, side_f.neg_y);

  // Output register; a zero-length separation gives no force
  always_ff @(posedge clk) begin
    force_x <= side_f.zero ? '0 : rx.value;
    force_y <= side_f.zero ? '0 : ry.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saturated <= 1'b0;
    end else begin
      saturated <= vp[TF-1] && !side_f.zero && (rx.clip || ry.clip);
    end
  end

  assign done = vp[TF];

endmodule

[sv/gpf_delay.sv]
`timescale 1ns / 1ps
module gpf_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [D];

  // Shift the word along one place per cycle
  always_ff @(posedge clk) begin
    sr[0] <= d;
    for (int k = 1; k < D; k++) begin
      sr[k] <= sr[k-1];
    end
  end

  assign q = sr[D-1];

endmodule

[sv/gpf_mul.sv]
`timescale 1ns / 1ps
module gpf_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic             clk,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  import gpf_pkg::*;

  localparam int NCH = (WA + MUL_CH - 1) / MUL_CH;
  localparam int AP  = NCH * MUL_CH;
  localparam int PW  = WA + WB;

  logic [AP-1:0] a_r   [NCH];
  logic [WB-1:0] b_r   [NCH];
  logic [PW-1:0] acc_r [NCH];

  // One slice of a per stage, accumulated into the running product
  for (genvar k = 0; k < NCH; k++) begin : g_stage
    logic [AP-1:0]        a_in;
    logic [WB-1:0]        b_in;
    logic [PW-1:0]        acc_in;
    logic [MUL_CH+WB-1:0] pp;

    if (k == 0) begin : g_first
      assign a_in   = AP'(a);
      assign b_in   = b;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    assign pp = a_in[k*MUL_CH +: MUL_CH] * b_in;

    always_ff @(posedge clk) begin
      a_r[k]   <= a_in;
      b_r[k]   <= b_in;
      acc_r[k] <= acc_in + (PW'(pp) << (k * MUL_CH));
    end
  end

  assign p = acc_r[NCH-1];

endmodule

[sv/gpf_sqrt.sv]
`timescale 1ns / 1ps
module gpf_sqrt #(
  parameter  int IW = 66,
  localparam int OW = (IW + 1) / 2
) (
  input  logic          clk,
  input  logic [IW-1:0] x,
  output logic [OW-1:0] root
);

  logic [OW:0]     rem_r  [OW];
  logic [OW-1:0]   root_r [OW];
  logic [2*OW-1:0] x_r    [OW];

  // One root bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [OW:0]     rem_in;
    logic [OW-1:0]   root_in;
    logic [2*OW-1:0] x_in;
    logic [OW+2:0]   r2;
    logic [OW+2:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = (2*OW)'(x);
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
    end

    assign r2    = {rem_in, x_in[2*OW-1 -: 2]};
    assign trial = (OW+3)'({root_in, 2'b01});
    assign ge    = r2 >= trial;

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? (OW+1)'(r2 - trial) : (OW+1)'(r2);
      root_r[k] <= {root_in[OW-2:0], ge};
      x_r[k]    <= x_in << 2;
    end
  end

  assign root = root_r[OW-1];

endmodule

[sv/gpf_div.sv]
`timescale 1ns / 1ps
module gpf_div #(
  parameter int NW = 48,
  parameter int DW = 34
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [DW-1:0] den_r [NW];

  // Restoring division, one quotient bit per stage; numerator bits
  // leave at the top of nq while quotient bits enter at the bottom
  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [NW-1:0] nq_p;
    logic [DW-1:0] den_p;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_p = rem_in;
      assign nq_p  = num_in;
      assign den_p = den;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign nq_p  = nq_r[k-1];
      assign den_p = den_r[k-1];
    end

    assign trial = {rem_p, nq_p[NW-1]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
      nq_r[k]  <= {nq_p[NW-2:0], ge};
      den_r[k] <= den_p;
    end
  end

  assign quo = nq_r[NW-1];

endmodule

[sv/gpf_checker.sv]
`timescale 1ns / 1ps
`include "gravity_pair_force_2d_assert.svh"
module gpf_checker #(
  parameter int POS_WIDTH = 32
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic signed [gpf_pkg::OUT_W-1:0] force_x,
  input logic signed [gpf_pkg::OUT_W-1:0] force_y,
  input logic                           saturated
);

  import gpf_pkg::*;

  localparam int LAT = gpf_result_lat(POS_WIDTH);

  // Every result traces back to a transfer in, at the offset that gpf_result_lat gives
  `GPF_ASSERT_NOW(a_done_has_item, done, $past(start && !busy, LAT))

  // The clip flag only shows with a result
  `GPF_ASSERT_NOW(a_sat_with_done, saturated, done)

  // A clipped result has a component at a range limit
  `GPF_ASSERT_NOW(a_sat_at_limit, done && saturated,
    (force_x == $signed(OUT_POS_MAX)) || (force_x == $signed(OUT_NEG_MAG))
    || (force_y == $signed(OUT_POS_MAX)) || (force_y == $signed(OUT_NEG_MAG)))

endmodule

bind gravity_pair_force_2d gpf_checker #(.POS_WIDTH(POS_WIDTH)) u_gpf_checker (.*);
